/* rtl/sarg_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package sarg_pkg;
	localparam int FracBitsDefault = 8;
	localparam int PosWidthDefault = 32;
	localparam int CfgWidth = 24;
	localparam int StepWidth = 32;

	typedef enum logic [2:0] {
		ACT_TICK = 3'd0,
		ACT_MOVE = 3'd1,
		ACT_SETPOS = 3'd2,
		ACT_STOP = 3'd3,
		ACT_HALT = 3'd4
	} action_t;

	localparam logic [1:0] REG_FIRST = 2'd0;
	localparam logic [1:0] REG_MIN = 2'd1;
	localparam logic [1:0] REG_AUTO = 2'd2;

	typedef enum logic [3:0] {
		OP_NONE = 4'd0,
		OP_TICK = 4'd1,
		OP_SETPOS = 4'd2,
		OP_HALT = 4'd3,
		OP_SS_START = 4'd4,
		OP_MOVE_CHECK = 4'd5,
		OP_STOP_TGT = 4'd6,
		OP_DECIDE = 4'd7,
		OP_Q_START = 4'd8,
		OP_APPLY = 4'd9,
		OP_RESULT = 4'd10,
		OP_WAIT = 4'd11
	} op_t;

	typedef struct packed {
		op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic div_done;
		logic stepped;
		logic need_ramp;
		logic iv_zero;
	} dp_sts_t;
endpackage
`default_nettype wire

/* rtl/stepper_accel_ramp_generator_top.sv */
`timescale 1ns / 1ps
// A tick without a step or a simple command needs no division. A step, or a move that
// changes the target, runs the serial divider for steps-to-stop and, when a ramp quotient
// is needed, again for the ramp quotient; a decelerating stop adds one more division.
// One item is handled at a time; the next item is taken as the result transfer completes.
// Reset (arst_n low, asynchronous) clears position, target, ramp and registers to defaults.
`default_nettype none
module stepper_accel_ramp_generator_top #(
	parameter int FRAC_BITS = sarg_pkg::FracBitsDefault,
	parameter int POS_WIDTH = sarg_pkg::PosWidthDefault
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [2:0] action,
	input wire logic signed [31:0] target_position,
	output logic out_valid,
	input wire logic out_stall,
	output logic step_pulse,
	output logic direction,
	output logic signed [31:0] position,
	output logic ready_res,
	output logic outputs_enabled,
	output logic moving,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [1:0] cfg_index,
	input wire logic [23:0] cfg_data
);
	import sarg_pkg::*;
	dp_cmd_t cmd;
	dp_sts_t sts;

	assign cfg_ready = 1'b1;

	sarg_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_action(action), .out_valid(out_valid), .out_stall(out_stall),
		.cmd(cmd), .sts(sts)
	);

	sarg_datapath #(.FRAC_BITS(FRAC_BITS), .POS_WIDTH(POS_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_target(target_position),
		.step_pulse(step_pulse), .direction(direction), .position(position),
		.ready_res(ready_res), .outputs_enabled(outputs_enabled), .moving(moving)
	);
endmodule
`default_nettype wire

/* rtl/sarg_divider.sv */
`timescale 1ns / 1ps
`default_nettype none
module sarg_divider #(
	parameter int W = 64
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [W-1:0] dividend,
	input wire logic [W-1:0] divisor,
	output logic busy,
	output logic done,
	output logic [W-1:0] quotient
);
	localparam int CW = $clog2(W + 1);
	logic [W-1:0] rem_q, quo_q, den_q;
	logic [CW-1:0] cnt_q;
	logic [W:0] trial;
	logic [W:0] shifted;

	assign shifted = {rem_q, quo_q[W-1]};
	assign trial = shifted - {1'b0, den_q};
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy <= 1'b1;
				cnt_q <= CW'(W);
			end else if (busy) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy) begin
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

/* rtl/sarg_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
module sarg_datapath #(
	parameter int FRAC_BITS = sarg_pkg::FracBitsDefault,
	parameter int POS_WIDTH = sarg_pkg::PosWidthDefault
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire sarg_pkg::dp_cmd_t cmd,
	output sarg_pkg::dp_sts_t sts,
	input wire logic cfg_valid,
	input wire logic [1:0] cfg_index,
	input wire logic [23:0] cfg_data,
	input wire logic [31:0] in_target,
	output logic step_pulse,
	output logic direction,
	output logic [31:0] position,
	output logic ready_res,
	output logic outputs_enabled,
	output logic moving
);
	import sarg_pkg::*;
	localparam int IVW = 24 + FRAC_BITS;
	localparam int DW = 64;
	localparam logic [IVW-1:0] IV_MAX = {IVW{1'b1}};
	localparam logic signed [StepWidth-1:0] STEP_CAP = {1'b0, {(StepWidth-1){1'b1}}};

	logic [23:0] first_q, min_q;
	logic auto_q;
	logic signed [POS_WIDTH-1:0] cur_q, tgt_q, mv_q;
	logic signed [StepWidth-1:0] n_q;
	logic [IVW-1:0] iv_q;
	logic [23:0] act_q;
	logic [31:0] el_q;
	logic dir_q, dis_q, rdy_q, stp_q;
	logic signed [POS_WIDTH-1:0] pos_in_q;
	logic signed [StepWidth+2:0] den_q;
	logic mv_stop_q;

	logic div_start, div_busy, div_done;
	logic [DW-1:0] div_a, div_b, div_q;
	logic signed [POS_WIDTH:0] gap;
	logic signed [POS_WIDTH+1:0] ext_steps;
	logic [DW-1:0] rq_sq;
	logic [16:0] t17;
	logic [33:0] tt;
	logic signed [StepWidth:0] ss;
	logic [IVW+1:0] cn_sum;
	logic [IVW+1:0] cmin;
	logic signed [StepWidth-1:0] n_new;
	logic [POS_WIDTH-1:0] stop_d;

	sarg_divider #(.W(DW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_a),
		.divisor(div_b), .busy(div_busy), .done(div_done), .quotient(div_q)
	);

	assign rq_sq = div_q[31:0] * div_q[31:0];
	assign t17 = div_q[32:16];
	assign tt = t17 * t17;

	always_comb begin
		if (iv_q == '0) ss = '0;
		else if (div_q[DW-1:32] == '0) ss = (StepWidth+1)'(rq_sq >> 34);
		else if (div_q[DW-1:33] != '0) ss = (StepWidth+1)'(STEP_CAP);
		else if ((tt >> 2) > 34'(STEP_CAP)) ss = (StepWidth+1)'(STEP_CAP);
		else ss = (StepWidth+1)'(tt >> 2);
	end

	assign gap = (POS_WIDTH+1)'(tgt_q) - (POS_WIDTH+1)'(cur_q);
	assign ext_steps = (POS_WIDTH+2)'(ss);
	assign cmin = (IVW+2)'((min_q == '0) ? 24'd1 : min_q) << FRAC_BITS;
	assign stop_d = POS_WIDTH'(ss) + POS_WIDTH'(1);

	always_comb begin
		div_start = 1'b0;
		div_a = DW'(first_q) << (FRAC_BITS + 16);
		div_b = DW'(iv_q);
		if (cmd.op == OP_SS_START) div_start = 1'b1;
		if (cmd.op == OP_Q_START) begin
			div_start = 1'b1;
			div_a = DW'(iv_q) << 1;
			div_b = DW'(den_q[StepWidth+2] ? -den_q : den_q);
		end
	end

	always_comb begin
		n_new = n_q;
		if (gap > 0) begin
			if (n_q > 0) begin
				if (ext_steps >= (POS_WIDTH+2)'(gap) || !dir_q) n_new = StepWidth'(-ss);
			end else if (n_q < 0) begin
				if (ext_steps < (POS_WIDTH+2)'(gap) && dir_q) n_new = -n_q;
			end
		end else if (gap < 0) begin
			if (n_q > 0) begin
				if (ext_steps >= -(POS_WIDTH+2)'(gap) || dir_q)
					n_new = StepWidth'(-ss);
			end else if (n_q < 0) begin
				if (ext_steps < -(POS_WIDTH+2)'(gap) && !dir_q) n_new = -n_q;
			end
		end
	end

	always_comb begin
		if (den_q[StepWidth+2]) cn_sum = (IVW+2)'(iv_q) + (IVW+2)'(div_q);
		else if (div_q > DW'(iv_q)) cn_sum = '0;
		else cn_sum = (IVW+2)'(iv_q) - (IVW+2)'(div_q);
		if (cn_sum < cmin) cn_sum = cmin;
		if (cn_sum > (IVW+2)'(IV_MAX)) cn_sum = (IVW+2)'(IV_MAX);
	end

	assign sts.div_done = div_done;
	assign sts.stepped = stp_q;
	assign sts.iv_zero = (iv_q == '0);
	assign sts.need_ramp = mv_stop_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= '0; min_q <= 24'd1; auto_q <= 1'b0;
			cur_q <= '0; tgt_q <= '0; n_q <= '0; iv_q <= '0; act_q <= '0;
			el_q <= '0; dir_q <= 1'b0; dis_q <= 1'b0; rdy_q <= 1'b0; stp_q <= 1'b0;
			pos_in_q <= '0; den_q <= '0;
			mv_q <= '0; mv_stop_q <= 1'b0;
			step_pulse <= 1'b0; direction <= 1'b0; position <= '0; ready_res <= 1'b0;
			outputs_enabled <= 1'b1; moving <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_FIRST: first_q <= cfg_data;
					REG_MIN: min_q <= cfg_data;
					REG_AUTO: auto_q <= cfg_data[0];
					default: ;
				endcase
			end
			case (cmd.op)
				OP_NONE: begin
					pos_in_q <= POS_WIDTH'(signed'(in_target));
					rdy_q <= 1'b0;
					stp_q <= 1'b0;
					mv_stop_q <= 1'b0;
				end
				OP_TICK: begin
					if (el_q != '1 && !(act_q != '0 && (el_q + 1) >= 32'(act_q)))
						el_q <= el_q + 1;
					if (act_q != '0 && ((el_q == '1) || (el_q + 1) >= 32'(act_q))) begin
						cur_q <= dir_q ? cur_q + 1'b1 : cur_q - 1'b1;
						el_q <= '0;
						stp_q <= 1'b1;
					end
				end
				OP_SETPOS: begin
					tgt_q <= pos_in_q; cur_q <= pos_in_q; n_q <= '0;
					iv_q <= '0; act_q <= '0;
				end
				OP_HALT: begin
					tgt_q <= cur_q; act_q <= '0; iv_q <= '0; el_q <= '1; n_q <= '0;
					rdy_q <= 1'b1;
					if (auto_q) dis_q <= 1'b1;
				end
				OP_SS_START: ;
				OP_STOP_TGT: begin
					mv_q <= dir_q ? cur_q + signed'(stop_d) : cur_q - signed'(stop_d);
				end
				OP_MOVE_CHECK: begin
					if (tgt_q == mv_q) begin
						if (tgt_q == cur_q) begin
							rdy_q <= 1'b1;
							if (auto_q) dis_q <= 1'b1;
						end
					end else begin
						if (auto_q) dis_q <= 1'b0;
						tgt_q <= mv_q;
						mv_stop_q <= 1'b1;
					end
				end
				OP_DECIDE: begin
					if (gap == 0 && ss <= 1) begin
						iv_q <= '0; act_q <= '0; n_q <= '0; rdy_q <= 1'b1;
						if (auto_q) dis_q <= 1'b1;
						mv_stop_q <= 1'b0;
					end else if (n_new == 0) begin
						iv_q <= IVW'(first_q) << FRAC_BITS;
						act_q <= first_q;
						dir_q <= (gap > 0);
						n_q <= 1;
						mv_stop_q <= 1'b0;
					end else begin
						n_q <= n_new;
						mv_stop_q <= 1'b1;
					end
				end
				OP_Q_START: ;
				OP_APPLY: begin
					iv_q <= cn_sum[IVW-1:0];
					act_q <= cn_sum[IVW-1:FRAC_BITS];
					if (n_q < STEP_CAP) n_q <= n_q + 1;
				end
				OP_RESULT: begin
					step_pulse <= stp_q; direction <= dir_q;
					position <= 32'(cur_q); ready_res <= rdy_q;
					outputs_enabled <= !dis_q; moving <= (act_q != '0);
				end
				default: ;
			endcase
			if (cmd.op == OP_DECIDE) den_q <= 4 * (StepWidth+3)'(n_new) + 1;
			if (cmd.op == OP_NONE) mv_q <= POS_WIDTH'(signed'(in_target));
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) div_start |-> !div_busy)
		else $error("division started while busy");
	assert property (@(posedge clk) disable iff (!arst_n) div_done |-> !div_busy)
		else $error("division done while busy");
	assert property (@(posedge clk) disable iff (!arst_n) cmd.op == OP_APPLY |-> div_done)
		else $error("ramp applied without a quotient");
endmodule
`default_nettype wire

/* rtl/sarg_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module sarg_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [2:0] in_action,
	output logic out_valid,
	input wire logic out_stall,
	output sarg_pkg::dp_cmd_t cmd,
	input wire sarg_pkg::dp_sts_t sts
);
	import sarg_pkg::*;
	typedef enum logic [9:0] {
		S_IDLE = 10'b0000000001,
		S_DISP = 10'b0000000010,
		S_STEP = 10'b0000000100,
		S_SS = 10'b0000001000,
		S_SSW = 10'b0000010000,
		S_QW = 10'b0000100000,
		S_OUT = 10'b0001000000,
		S_HOLD = 10'b0010000000,
		S_MOVE = 10'b0100000000,
		S_QS = 10'b1000000000
	} state_t;
	state_t state_q;
	logic [2:0] act_q;
	logic stop_q;

	assign in_stall = (state_q != S_IDLE) && !(state_q == S_HOLD && !out_stall);

	always_comb begin
		cmd.op = OP_WAIT;
		case (state_q)
			S_IDLE, S_HOLD: cmd.op = OP_NONE;
			S_DISP: begin
				case (act_q)
					ACT_TICK: cmd.op = OP_TICK;
					ACT_SETPOS: cmd.op = OP_SETPOS;
					ACT_HALT: cmd.op = OP_HALT;
					ACT_MOVE: cmd.op = OP_MOVE_CHECK;
					ACT_STOP: cmd.op = sts.iv_zero ? OP_RESULT : OP_SS_START;
					default: cmd.op = OP_RESULT;
				endcase
			end
			S_STEP: cmd.op = sts.stepped ? OP_SS_START : OP_RESULT;
			S_MOVE: cmd.op = sts.need_ramp ? OP_SS_START : OP_RESULT;
			S_SS: cmd.op = OP_MOVE_CHECK;
			S_SSW: if (sts.div_done) cmd.op = stop_q ? OP_STOP_TGT : OP_DECIDE;
			S_QS: cmd.op = sts.need_ramp ? OP_Q_START : OP_RESULT;
			S_QW: if (sts.div_done) cmd.op = OP_APPLY;
			S_OUT: cmd.op = OP_RESULT;
			default: cmd.op = OP_WAIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; act_q <= '0; stop_q <= 1'b0; out_valid <= 1'b0;
		end else begin
			if (out_valid && !out_stall) out_valid <= 1'b0;
			case (state_q)
				S_IDLE, S_HOLD: begin
					if (state_q == S_HOLD && out_stall) state_q <= S_HOLD;
					else if (in_valid) begin
						act_q <= in_action; state_q <= S_DISP;
					end else state_q <= S_IDLE;
				end
				S_DISP: begin
					stop_q <= (act_q == ACT_STOP);
					case (act_q)
						ACT_TICK: state_q <= S_STEP;
						ACT_SETPOS, ACT_HALT: state_q <= S_OUT;
						ACT_MOVE: state_q <= S_MOVE;
						ACT_STOP: state_q <= sts.iv_zero ? S_HOLD : S_SSW;
						default: state_q <= S_HOLD;
					endcase
					if (act_q != ACT_TICK && act_q != ACT_MOVE && act_q != ACT_SETPOS
						&& act_q != ACT_HALT && !(act_q == ACT_STOP && !sts.iv_zero))
						out_valid <= 1'b1;
				end
				S_STEP: begin
					stop_q <= 1'b0;
					if (sts.stepped) state_q <= S_SSW;
					else begin state_q <= S_HOLD; out_valid <= 1'b1; end
				end
				S_MOVE: begin
					stop_q <= 1'b0;
					if (sts.need_ramp) state_q <= S_SSW;
					else begin state_q <= S_HOLD; out_valid <= 1'b1; end
				end
				S_SSW: if (sts.div_done) begin
					if (stop_q) begin stop_q <= 1'b0; state_q <= S_SS; end
					else state_q <= S_QS;
				end
				S_SS: state_q <= S_MOVE;
				S_QS: begin
					if (sts.need_ramp) state_q <= S_QW;
					else begin state_q <= S_HOLD; out_valid <= 1'b1; end
				end
				S_QW: if (sts.div_done) state_q <= S_OUT;
				S_OUT: begin state_q <= S_HOLD; out_valid <= 1'b1; end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");
	assert property (@(posedge clk) disable iff (!arst_n) state_q == S_DISP |-> in_stall)
		else $error("input taken while busy");
	assert property (@(posedge clk) disable iff (!arst_n) $rose(out_valid) |-> state_q == S_HOLD)
		else $error("result raised outside hold");
endmodule
`default_nettype wire

/* dv/stepper_accel_ramp_generator_top_tb.sv */
`timescale 1ns / 1ps
module stepper_accel_ramp_generator_top_tb;
	import sarg_pkg::*;

	localparam int FB = FracBitsDefault;
	localparam longint STEP_CAP = 64'h7FFF_FFFF;
	localparam longint unsigned IV_MAX = (64'd1 << (24 + FB)) - 1;
	localparam int DRAIN_CYCLES = 400;

	typedef struct packed {
		logic stp;
		logic dir;
		logic signed [31:0] pos;
		logic rdy;
		logic en;
		logic mov;
	} motion_t;

	typedef struct {
		logic [2:0] act;
		logic signed [31:0] tp;
		bit typed;
		motion_t want;
	} plan_row_t;

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	logic [2:0] action;
	logic signed [31:0] target_position;
	logic step_pulse, direction, ready_res, outputs_enabled, moving;
	logic signed [31:0] position;
	logic cfg_valid, cfg_ready;
	logic [1:0] cfg_index;
	logic [23:0] cfg_data;

	stepper_accel_ramp_generator_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .target_position(target_position),
		.out_valid(out_valid), .out_stall(out_stall),
		.step_pulse(step_pulse), .direction(direction), .position(position),
		.ready_res(ready_res), .outputs_enabled(outputs_enabled), .moving(moving),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	logic [23:0] cfg_first, cfg_min;
	logic cfg_auto;
	logic signed [31:0] m_cur, m_tgt;
	longint m_n;
	longint unsigned m_iv;
	logic [23:0] m_act;
	logic [31:0] m_elapsed;
	logic m_dir, m_dis, m_rdy;

	motion_t motion_q[$];
	plan_row_t plan[$];
	int err_cnt = 0;
	int item_cnt = 0;
	int step_cnt = 0;
	int snd_pct = 0;
	int rcv_pct = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("Timeout with %0d results outstanding.", motion_q.size());
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic longint stop_count();
		longint unsigned rq, t, s;
		if (m_iv == 0)
			return 0;
		rq = (64'(cfg_first) << (FB + 16)) / m_iv;
		if (rq < 64'h1_0000_0000)
			return longint'((rq * rq) >> 34);
		t = rq >> 16;
		if (t >= 64'h2_0000)
			return STEP_CAP;
		s = (t * t) >> 2;
		return (s > STEP_CAP) ? STEP_CAP : longint'(s);
	endfunction

	function automatic void note_ready();
		m_rdy = 1'b1;
		if (cfg_auto)
			m_dis = 1'b1;
	endfunction

	function automatic void advance_ramp();
		longint gap, steps, den;
		longint unsigned mag, q, cn, cmin;
		gap = longint'(m_tgt) - longint'(m_cur);
		steps = stop_count();
		cmin = 64'((cfg_min == 0) ? 24'd1 : cfg_min) << FB;
		if (gap == 0 && steps <= 1) begin
			m_iv = 0;
			m_act = '0;
			m_n = 0;
			note_ready();
			return;
		end
		if (gap > 0) begin
			if (m_n > 0) begin
				if (steps >= gap || !m_dir)
					m_n = -steps;
			end else if (m_n < 0) begin
				if (steps < gap && m_dir)
					m_n = -m_n;
			end
		end else if (gap < 0) begin
			if (m_n > 0) begin
				if (steps >= -gap || m_dir)
					m_n = -steps;
			end else if (m_n < 0) begin
				if (steps < -gap && !m_dir)
					m_n = -m_n;
			end
		end
		if (m_n == 0) begin
			m_iv = 64'(cfg_first) << FB;
			m_dir = (gap > 0);
		end else begin
			den = 4 * m_n + 1;
			mag = (den > 0) ? den : -den;
			q = (m_iv * 2) / mag;
			cn = (den > 0) ? m_iv - q : m_iv + q;
			if (cn < cmin)
				cn = cmin;
			if (cn > IV_MAX)
				cn = IV_MAX;
			m_iv = cn;
		end
		if (m_n < STEP_CAP)
			m_n++;
		m_act = 24'(m_iv >> FB);
	endfunction

	function automatic void seek(logic signed [31:0] p);
		if (m_tgt == p) begin
			if (m_tgt == m_cur)
				note_ready();
			return;
		end
		if (cfg_auto && m_dis)
			m_dis = 1'b0;
		m_tgt = p;
		advance_ramp();
	endfunction

	function automatic motion_t predict_motion(logic [2:0] act, logic signed [31:0] tp);
		motion_t r;
		logic stp;
		longint d;
		m_rdy = 1'b0;
		stp = 1'b0;
		case (act)
			ACT_TICK: begin
				if (m_elapsed != '1)
					m_elapsed++;
				if (m_act != 0 && m_elapsed >= {8'd0, m_act}) begin
					m_cur = m_dir ? m_cur + 32'sd1 : m_cur - 32'sd1;
					m_elapsed = '0;
					stp = 1'b1;
					advance_ramp();
				end
			end
			ACT_MOVE: seek(tp);
			ACT_SETPOS: begin
				m_tgt = tp;
				m_cur = tp;
				m_n = 0;
				m_iv = 0;
				m_act = '0;
			end
			ACT_STOP: begin
				if (m_iv != 0) begin
					d = stop_count() + 1;
					seek(m_dir ? m_cur + 32'(d) : m_cur - 32'(d));
				end
			end
			ACT_HALT: begin
				m_tgt = m_cur;
				m_act = '0;
				m_iv = 0;
				m_elapsed = '1;
				m_n = 0;
				note_ready();
			end
			default: ;
		endcase
		r.stp = stp;
		r.dir = m_dir;
		r.pos = m_cur;
		r.rdy = m_rdy;
		r.en = ~m_dis;
		r.mov = (m_act != 0);
		return r;
	endfunction

	task automatic report(string what, longint got, longint want);
		$display("Mismatch on %s: got %0h, expected %0h", what, got, want);
		err_cnt++;
	endtask

	always @(negedge clk)
		out_stall <= ($urandom_range(0, 99) < rcv_pct);

	always @(posedge clk) begin
		motion_t w;
		if (out_valid && !out_stall) begin
			if (motion_q.size() == 0) begin
				report("unexpected transfer", position, 0);
			end else begin
				w = motion_q.pop_front();
				if (step_pulse !== w.stp) report("step_pulse", step_pulse, w.stp);
				if (direction !== w.dir) report("direction", direction, w.dir);
				if (position !== w.pos) report("position", position, w.pos);
				if (ready_res !== w.rdy) report("ready_res", ready_res, w.rdy);
				if (outputs_enabled !== w.en) report("outputs_enabled", outputs_enabled, w.en);
				if (moving !== w.mov) report("moving", moving, w.mov);
			end
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [23:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_FIRST: cfg_first = val;
			REG_MIN: cfg_min = val;
			default: cfg_auto = val[0];
		endcase
		@(negedge clk);
	endtask

	task automatic configure(logic [23:0] first_iv, logic [23:0] min_iv, logic auto_off);
		write_reg(REG_FIRST, first_iv);
		write_reg(REG_MIN, min_iv);
		write_reg(REG_AUTO, {23'd0, auto_off});
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic send(logic [2:0] act, logic signed [31:0] tp, bit typed, motion_t want);
		motion_t pm;
		if ($urandom_range(0, 99) < snd_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		target_position <= tp;
		do @(posedge clk); while (in_stall);
		pm = predict_motion(act, tp);
		motion_q.push_back(typed ? want : pm);
		item_cnt++;
		if (pm.stp)
			step_cnt++;
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (motion_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic random_items(int count);
		logic [2:0] act;
		logic signed [31:0] tp;
		int r;
		repeat (count) begin
			r = $urandom_range(0, 99);
			tp = $urandom;
			if (r < 68) begin
				act = ACT_TICK;
			end else if (r < 80) begin
				act = ACT_MOVE;
				tp = m_cur + 32'($urandom_range(0, 24)) - 32'sd12;
			end else if (r < 83) begin
				act = ACT_MOVE;
			end else if (r < 87) begin
				act = ACT_SETPOS;
				if ($urandom_range(0, 2) != 0)
					tp = m_cur + 32'($urandom_range(0, 8)) - 32'sd4;
			end else if (r < 92) begin
				act = ACT_STOP;
			end else if (r < 95) begin
				act = ACT_HALT;
			end else if (r < 98) begin
				act = ACT_MOVE;
				tp = m_tgt;
			end else begin
				act = 3'($urandom_range(5, 7));
			end
			send(act, tp, 1'b0, '0);
		end
	endtask

	function automatic void plan_add(logic [2:0] act, logic signed [31:0] tp, bit typed,
			motion_t want);
		plan_row_t row;
		row.act = act;
		row.tp = tp;
		row.typed = typed;
		row.want = want;
		plan.push_back(row);
	endfunction

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		action = ACT_TICK;
		target_position = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_FIRST;
		cfg_data = '0;
		cfg_first = '0;
		cfg_min = 24'd1;
		cfg_auto = 1'b0;
		m_cur = '0;
		m_tgt = '0;
		m_n = 0;
		m_iv = 0;
		m_act = '0;
		m_elapsed = '0;
		m_dir = 1'b0;
		m_dis = 1'b0;
		m_rdy = 1'b0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		plan_add(ACT_TICK, 0, 1, '{0, 0, 32'sd0, 0, 1, 0});
		plan_add(3'd5, 32'h7FFF_FFFF, 1, '{0, 0, 32'sd0, 0, 1, 0});
		plan_add(3'd7, 32'h8000_0000, 1, '{0, 0, 32'sd0, 0, 1, 0});
		plan_add(ACT_SETPOS, 32'h7FFF_FFFF, 1, '{0, 0, 32'h7FFF_FFFF, 0, 1, 0});
		plan_add(ACT_SETPOS, 32'h8000_0000, 1, '{0, 0, 32'h8000_0000, 0, 1, 0});
		plan_add(ACT_HALT, 0, 1, '{0, 0, 32'h8000_0000, 1, 0, 0});
		plan_add(ACT_MOVE, 32'h8000_0000, 1, '{0, 0, 32'h8000_0000, 1, 0, 0});
		plan_add(ACT_MOVE, 32'h7FFF_FFFE, 0, '0);
		repeat (3) plan_add(ACT_TICK, 0, 0, '0);
		plan_add(ACT_STOP, 0, 0, '0);
		repeat (4) plan_add(ACT_TICK, 0, 0, '0);
		plan_add(ACT_SETPOS, -32'sd3, 0, '0);
		plan_add(ACT_STOP, 0, 0, '0);
		plan_add(ACT_HALT, 0, 0, '0);
		plan_add(ACT_MOVE, 32'sd2, 0, '0);
		repeat (5) plan_add(ACT_TICK, 0, 0, '0);

		snd_pct = 28;
		rcv_pct = 63;
		configure(24'd6, 24'd0, 1'b1);
		foreach (plan[i])
			send(plan[i].act, plan[i].tp, plan[i].typed, plan[i].want);
		random_items(130);
		drain();
		configure(24'd0, 24'hFF_FFFF, 1'b0);
		random_items(25);
		drain();

		snd_pct = 63;
		rcv_pct = 28;
		configure(24'hFF_FFFF, 24'd1, 1'b0);
		random_items(25);
		drain();
		configure(24'd20, 24'd3, 1'b1);
		random_items(120);
		drain();

		snd_pct = 0;
		rcv_pct = 0;
		configure(24'd5, 24'd1, 1'b1);
		random_items(130);
		drain();

		$display("Sent %0d items over five register settings; %0d of them took a step.",
			item_cnt, step_cnt);
		if (err_cnt == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches.", err_cnt);
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule

/* stepper_accel_ramp_generator_top.f */
rtl/sarg_pkg.sv
rtl/sarg_divider.sv
rtl/sarg_datapath.sv
rtl/sarg_ctrl.sv
rtl/stepper_accel_ramp_generator_top.sv
dv/stepper_accel_ramp_generator_top_tb.sv
